// ----- sv/stpt_pkg.sv -----
package stpt_pkg;

    localparam int FRAC_BITS  = 16;
    localparam int SEGS       = 8;
    localparam int ATAN_MAX   = 24;
    localparam int LO_THRUST  = (1000 * 65536 + 5000) / 10000;
    localparam int X_GRAV     = (981 * 65536 + 50) / 100;
    localparam int INTERP_IT  = 14;
    localparam int DERIV_IT   = 33;

    localparam int C_SPD [9] = '{0, 1000, 1500, 2000, 3500, 4500, 6000, 7000, 8000};
    localparam int C_PIT [9] = '{0, 1396, 1993, 1993, 1993, 2978, 2978, 3373, 3948};
    localparam int C_THR [9] = '{1000, 1000, 1000, 1500, 2000, 2000, 2500, 2500, 2500};

    // atan(2^-i), Q30
    localparam int C_ATAN [24] = '{
        843314856, 497837829, 263043836, 133525158, 67021686, 33543515,
        16775850, 8388437, 4194282, 2097149, 1048575, 524287,
        262143, 131071, 65535, 32767, 16383, 8191,
        4095, 2047, 1023, 511, 255, 127
    };

    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_CALC   = 6'b000010,
        ST_DIV    = 6'b000100,
        ST_CORDIC = 6'b001000,
        ST_FIN    = 6'b010000,
        ST_OUT    = 6'b100000
    } t_state;

    typedef struct packed {
        logic       start;
        logic [5:0] iters;
    } t_div_req;

    function automatic logic [31:0] ff_q(input int v);
        return 32'((v * 65536 + 5000) / 10000);
    endfunction

    function automatic logic [15:0] atan_t(input logic [4:0] i);
        return 16'((C_ATAN[i] + 8192) >>> 14);
    endfunction

    function automatic logic signed [63:0] round_shr(input logic signed [63:0] v);
        logic signed [63:0] half;
        half = 64'sd1 <<< (FRAC_BITS - 1);
        if (v >= 0)
            return (v + half) >>> FRAC_BITS;
        return -((-v + half) >>> FRAC_BITS);
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        if (v > 64'sd2147483647)
            return 32'sh7FFFFFFF;
        if (v < -64'sd2147483648)
            return 32'sh80000000;
        return 32'(v);
    endfunction

endpackage

// ----- sv/stpt_div.sv -----
module stpt_div
    import stpt_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_div_req    i_req,
    input  logic [49:0] i_num,
    input  logic [16:0] i_den,
    output logic        o_done,
    output logic [32:0] o_quo
);

    logic        r_busy, r_done;
    logic [5:0]  r_cnt;
    logic [49:0] r_rem, r_dsh;
    logic [32:0] r_q;
    logic        fits;

    assign fits = (r_rem >= r_dsh);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_req.iters;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 6'd1;
                if (r_cnt == 6'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= i_num;
            r_dsh <= 50'(i_den) << (i_req.iters - 6'd1);
            r_q   <= '0;
        end else if (r_busy) begin
            if (fits)
                r_rem <= r_rem - r_dsh;
            r_q   <= {r_q[31:0], fits};
            r_dsh <= r_dsh >> 1;
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_q;

endmodule

// ----- sv/speed_to_pitch_thrust_controller_top.sv -----
// Speed-to-pitch/thrust controller. Each input word (target speed, signed Q4.16;
// measured speed, Q3.16; tick time, Q1.16) yields one output word (pitch, thrust).
// One word is in flight at a time: o_in_ready is high only while idle.
// An accepted word runs through 14 steps on one shared 34x22 multiplier, two
// 14-step and one 33-step pass of the bit-serial divider, ITERS (ATAN_ITERATIONS
// capped at ATAN_MAX) CORDIC steps, the clamp state, the output state (held while
// i_out_ready is low) and the idle state. A zero tick skips the 33-step pass.
// Configuration writes are always accepted and should be made while idle.
module speed_to_pitch_thrust_controller_top
    import stpt_pkg::*;
#(
    parameter int ATAN_ITERATIONS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [3:0]         i_cfg_index,
    input  logic [31:0]        i_cfg_data,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic signed [19:0] i_speed_target,
    input  logic [18:0]        i_speed_measured,
    input  logic [16:0]        i_tick_seconds,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [16:0]        o_pitch_command,
    output logic [16:0]        o_thrust_command
);

    localparam int ITERS = (ATAN_ITERATIONS < ATAN_MAX) ? ATAN_ITERATIONS : ATAN_MAX;

    localparam logic [3:0] REG_KP = 4'd0, REG_KI = 4'd1, REG_KD = 4'd2, REG_W = 4'd3,
                           REG_IB = 4'd4, REG_SB = 4'd5, REG_PB = 4'd6, REG_TB = 4'd7;

    logic [20:0] r_kp, r_ki, r_kd;
    logic [16:0] r_w;
    logic [21:0] r_ib;
    logic [18:0] r_sb;
    logic [16:0] r_pb, r_tb;

    t_state r_state;
    logic [3:0] r_step, r_ret;

    logic signed [19:0] r_tgt;
    logic [18:0] r_meas;
    logic [16:0] r_dt;

    logic signed [31:0] r_fs, r_integ, r_prev, r_der, r_ffp, r_fft;
    logic signed [55:0] r_prod, r_acc0;
    logic signed [33:0] r_err, r_acc;
    logic [18:0] r_off;
    logic [15:0] r_dp, r_dth;
    logic [31:0] r_p0, r_t0;
    logic [16:0] r_dx;
    logic        r_big, r_neg;

    logic signed [35:0] r_cx, r_cy;
    logic signed [31:0] r_cz;
    logic [4:0]  r_ci;

    logic [16:0] r_pitch, r_thrust;

    logic signed [33:0] mul_a;
    logic signed [21:0] mul_b;
    logic [17:0] w_eff;

    t_div_req    div_req;
    logic [49:0] div_num;
    logic [16:0] div_den;
    logic        div_done;
    logic [32:0] div_q;

    logic [18:0] vc;
    logic [18:0] ff_off;
    logic [16:0] ff_dx;
    logic [31:0] ff_p0, ff_t0;
    logic [15:0] ff_dp, ff_dth;

    logic signed [63:0] integ_n, a_sum, pitch_s;
    logic signed [34:0] diff, sq;
    logic [33:0] mag;
    logic signed [35:0] cdx, cdy;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = (r_state == ST_OUT);
    assign o_pitch_command  = r_pitch;
    assign o_thrust_command = r_thrust;

    assign w_eff = (r_w > 17'd65536) ? 18'd65536 : {1'b0, r_w};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kp <= 21'd65536;
            r_ki <= 21'd13107;
            r_kd <= 21'd6554;
            r_w  <= 17'd13107;
            r_ib <= 22'd327680;
            r_sb <= 19'd52429;
            r_pb <= 17'd26214;
            r_tb <= 17'd26214;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_KP: r_kp <= i_cfg_data[20:0];
                REG_KI: r_ki <= i_cfg_data[20:0];
                REG_KD: r_kd <= i_cfg_data[20:0];
                REG_W:  r_w  <= i_cfg_data[16:0];
                REG_IB: r_ib <= i_cfg_data[21:0];
                REG_SB: r_sb <= i_cfg_data[18:0];
                REG_PB: r_pb <= i_cfg_data[16:0];
                REG_TB: r_tb <= i_cfg_data[16:0];
                default: ;
            endcase
        end
    end

    // shared multiplier operand select
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_step)
            4'd0:  begin mul_a = 34'(r_meas); mul_b = 22'(w_eff); end
            4'd1:  begin mul_a = 34'(r_fs); mul_b = 22'(18'd65536 - w_eff); end
            4'd3:  begin mul_a = 34'(r_off); mul_b = 22'(r_dp); end
            4'd5:  begin mul_a = 34'(r_off); mul_b = 22'(r_dth); end
            4'd7:  begin mul_a = r_err; mul_b = 22'(r_dt); end
            4'd8:  begin mul_a = 34'(sat32(64'(r_err))); mul_b = 22'(r_kp); end
            4'd9:  begin mul_a = 34'(r_integ); mul_b = 22'(r_ki); end
            4'd12: begin mul_a = 34'(r_der); mul_b = 22'(r_kd); end
            default: ;
        endcase
    end

    // feedforward segment search, lowest matching segment wins
    always_comb begin
        if (r_tgt < 0)
            vc = '0;
        else if (19'(r_tgt) > r_sb)
            vc = r_sb;
        else
            vc = 19'(r_tgt);
        ff_off = '0;
        ff_dx  = 17'd1;
        ff_p0  = '0;
        ff_t0  = '0;
        ff_dp  = '0;
        ff_dth = '0;
        for (int i = SEGS - 1; i >= 0; i--) begin
            if (32'(vc) >= ff_q(C_SPD[i]) && 32'(vc) <= ff_q(C_SPD[i + 1])) begin
                ff_off = vc - 19'(ff_q(C_SPD[i]));
                ff_dx  = 17'(ff_q(C_SPD[i + 1]) - ff_q(C_SPD[i]));
                ff_p0  = ff_q(C_PIT[i]);
                ff_t0  = ff_q(C_THR[i]);
                ff_dp  = 16'(ff_q(C_PIT[i + 1]) - ff_q(C_PIT[i]));
                ff_dth = 16'(ff_q(C_THR[i + 1]) - ff_q(C_THR[i]));
            end
        end
    end

    always_comb begin
        integ_n = 64'(r_integ) + round_shr(64'(r_prod));
        if (integ_n > $signed({42'd0, r_ib}))
            integ_n = $signed({42'd0, r_ib});
        if (integ_n < -$signed({42'd0, r_ib}))
            integ_n = -$signed({42'd0, r_ib});
        diff  = 35'(r_err) - 35'(r_prev);
        mag   = (diff < 0) ? 34'(-diff) : 34'(diff);
        sq    = r_neg ? -35'($signed({2'b0, div_q})) : 35'($signed({2'b0, div_q}));
        a_sum = 64'(r_acc) + 64'(sat32(round_shr(64'(r_prod))));
        cdx   = r_cy >>> r_ci;
        cdy   = r_cx >>> r_ci;
        pitch_s = 64'(r_ffp) + 64'(r_cz);
    end

    always_comb begin
        div_req.start = 1'b0;
        div_req.iters = 6'(INTERP_IT);
        div_num = 50'(r_prod) + 50'(r_dx >> 1);
        div_den = r_dx;
        if (r_state == ST_CALC) begin
            case (r_step)
                4'd4, 4'd6: div_req.start = 1'b1;
                4'd10: begin
                    div_req.start = (r_dt != '0);
                    div_req.iters = 6'(DERIV_IT);
                    div_num = {mag, 16'd0};
                    div_den = r_dt;
                end
                default: ;
            endcase
        end
    end

    stpt_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quo   (div_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_step  <= '0;
            r_ret   <= '0;
            r_ci    <= '0;
            r_fs    <= '0;
            r_integ <= '0;
            r_prev  <= '0;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (i_in_valid) begin
                        r_state <= ST_CALC;
                        r_step  <= '0;
                    end
                end
                ST_CALC: begin
                    r_step <= r_step + 4'd1;
                    case (r_step)
                        4'd2: r_fs <= sat32(round_shr(64'(r_acc0) + 64'(r_prod)));
                        4'd4, 4'd6: begin
                            r_state <= ST_DIV;
                            r_ret   <= r_step + 4'd1;
                        end
                        4'd8: r_integ <= 32'(integ_n);
                        4'd10: begin
                            if (r_dt != '0) begin
                                r_state <= ST_DIV;
                                r_ret   <= 4'd11;
                            end
                        end
                        4'd12: r_prev <= sat32(64'(r_err));
                        4'd13: begin
                            r_state <= ST_CORDIC;
                            r_ci    <= '0;
                        end
                        default: ;
                    endcase
                end
                ST_DIV: begin
                    if (div_done) begin
                        r_state <= ST_CALC;
                        r_step  <= r_ret;
                    end
                end
                ST_CORDIC: begin
                    r_ci <= r_ci + 5'd1;
                    if (r_ci == 5'(ITERS - 1))
                        r_state <= ST_FIN;
                end
                ST_FIN: r_state <= ST_OUT;
                ST_OUT: begin
                    if (i_out_ready)
                        r_state <= ST_IDLE;
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;
        if (r_state == ST_IDLE && i_in_valid) begin
            r_tgt  <= i_speed_target;
            r_meas <= i_speed_measured;
            r_dt   <= i_tick_seconds;
        end
        if (r_state == ST_CALC) begin
            case (r_step)
                4'd1: r_acc0 <= r_prod;
                4'd2: begin
                    r_off <= ff_off;
                    r_dx  <= ff_dx;
                    r_p0  <= ff_p0;
                    r_t0  <= ff_t0;
                    r_dp  <= ff_dp;
                    r_dth <= ff_dth;
                end
                4'd3: r_err <= 34'(r_tgt) - 34'(r_fs);
                4'd9: r_acc <= 34'(sat32(round_shr(64'(r_prod))));
                4'd10: begin
                    r_acc <= r_acc + 34'(sat32(round_shr(64'(r_prod))));
                    r_big <= ({mag, 16'd0} >= {r_dt, 33'd0});
                    r_neg <= (diff < 0);
                end
                4'd11: begin
                    if (r_dt == '0)
                        r_der <= '0;
                    else if (r_big)
                        r_der <= r_neg ? 32'sh80000000 : 32'sh7FFFFFFF;
                    else
                        r_der <= sat32(64'(sq));
                end
                4'd13: begin
                    r_cx <= 36'(X_GRAV);
                    r_cy <= 36'(sat32(a_sum));
                    r_cz <= '0;
                end
                default: ;
            endcase
        end
        if (r_state == ST_DIV && div_done) begin
            if (r_ret == 4'd5)
                r_ffp <= $signed(r_p0 + 32'(div_q));
            if (r_ret == 4'd7)
                r_fft <= $signed(r_t0 + 32'(div_q));
        end
        if (r_state == ST_CORDIC) begin
            if (r_cy >= 0) begin
                r_cx <= r_cx + cdx;
                r_cy <= r_cy - cdy;
                r_cz <= r_cz + 32'(atan_t(r_ci));
            end else begin
                r_cx <= r_cx - cdx;
                r_cy <= r_cy + cdy;
                r_cz <= r_cz - 32'(atan_t(r_ci));
            end
        end
        if (r_state == ST_FIN) begin
            if (pitch_s < 0)
                r_pitch <= '0;
            else if (pitch_s > 64'(r_pb))
                r_pitch <= r_pb;
            else
                r_pitch <= 17'(pitch_s);
            if (r_tb < 17'(LO_THRUST))
                r_thrust <= r_tb;
            else if (r_fft < LO_THRUST)
                r_thrust <= 17'(LO_THRUST);
            else if (r_fft > $signed({15'd0, r_tb}))
                r_thrust <= r_tb;
            else
                r_thrust <= 17'(r_fft);
        end
    end

    a_one_side: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_in_ready && o_out_valid))
        else $error("ready and result valid together");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("ready right after accepting a word");

    a_pitch_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !$rose(o_out_valid)) |-> $stable(o_pitch_command))
        else $error("pitch changed while held");

    a_thrust_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> o_thrust_command <= r_tb)
        else $error("thrust above bound");

endmodule
